/* design/lzrp_pkg.sv */
`default_nettype none
package lzrp_pkg;

    localparam int ADDR_W  = 17;
    localparam int OFF_W   = 18;
    localparam int LEN_W   = 11;
    localparam int LREM_W  = 7;
    localparam int MAX_BPR = 32;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam logic [7:0] BYTE_MAGIC      = 8'h10;
    localparam logic [7:0] BYTE_MAGIC_MASK = 8'hfe;
    localparam logic [7:0] BYTE_HDR1       = 8'hfb;
    localparam logic [7:0] CMD_TERM_MIN    = 8'hfc;
    localparam logic [7:0] CMD_LONG_MIN    = 8'he0;
    localparam logic [7:0] CMD_MED_MIN     = 8'h80;
    localparam logic [7:0] CMD_BIG_MIN     = 8'hc0;
    localparam logic [2:0] SKIP_SHORT      = 3'd3;
    localparam logic [2:0] SKIP_LONG       = 3'd6;

    typedef enum logic [1:0] {
        K_COPY,
        K_LONGLIT,
        K_TERM
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [LREM_W-1:0]   lit_n;
        logic [LEN_W-1:0]    len;
        logic [OFF_W-1:0]    off;
    } t_dec;

    // one queue entry: the work caused by one input byte
    typedef struct packed {
        logic                has_lit;
        logic [7:0]          lit;
        logic [LEN_W-1:0]    len;
        logic [ADDR_W-1:0]   wr_addr;
        logic [ADDR_W-1:0]   rd_addr;
        logic                is_end;
        logic                is_err;
    } t_cmd;

    function automatic logic [2:0] cmd_size(input logic [7:0] c0);
        logic [2:0] s;
        if (c0 >= CMD_LONG_MIN) s = 3'd1;
        else if (c0 < CMD_MED_MIN) s = 3'd2;
        else if (c0 < CMD_BIG_MIN) s = 3'd3;
        else s = 3'd4;
        return s;
    endfunction

    function automatic t_dec decode(input logic [7:0] c0, input logic [7:0] a,
                                    input logic [7:0] b, input logic [7:0] c);
        t_dec d;
        d = '0;
        if (c0 >= CMD_TERM_MIN) begin
            d.kind  = K_TERM;
            d.lit_n = {5'd0, c0[1:0]};
        end else if (c0 >= CMD_LONG_MIN) begin
            d.kind  = K_LONGLIT;
            d.lit_n = {c0[4:0], 2'b00} + 7'd4;
        end else if (c0 < CMD_MED_MIN) begin
            d.kind  = K_COPY;
            d.lit_n = {5'd0, c0[1:0]};
            d.len   = {8'd0, c0[4:2]} + 11'd3;
            d.off   = {8'd0, c0[6:5], a} + 18'd1;
        end else if (c0 < CMD_BIG_MIN) begin
            d.kind  = K_COPY;
            d.lit_n = {5'd0, a[7:6]};
            d.len   = {5'd0, c0[5:0]} + 11'd4;
            d.off   = {4'd0, a[5:0], b} + 18'd1;
        end else begin
            d.kind  = K_COPY;
            d.lit_n = {5'd0, c0[1:0]};
            d.len   = {1'b0, c0[3:2], c} + 11'd5;
            d.off   = {1'b0, c0[4], a, b} + 18'd1;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

/* design/lzrp_front.sv */
`default_nettype none
module lzrp_front import lzrp_pkg::*; #(
    parameter int WINDOW_BYTES = 131072
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_frame_start,
    output logic            o_ready,
    input  wire logic       i_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    typedef enum logic [3:0] {
        P_HDR0, P_HDR1, P_SKIP, P_CMD0, P_CMD1, P_CMD2, P_CMD3, P_LIT, P_DONE, P_ERR
    } t_phase;

    localparam logic [OFF_W:0] WIN = (OFF_W+1)'(WINDOW_BYTES);

    t_phase              r_phase, n_phase, cur_phase;
    logic [7:0]          r_c0, r_c1, r_c2, n_c0, n_c1, n_c2;
    logic [LREM_W-1:0]   r_lrem, n_lrem;
    t_kind               r_kind, n_kind;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [2:0]          r_skip, n_skip, cur_skip;
    logic [ADDR_W-1:0]   r_wp, n_wp, cur_wp, wp1;
    logic [ADDR_W:0]     r_bw, n_bw, cur_bw, bw1;
    logic [7:0]          d0, d1, d2, d3;
    t_dec                dec;
    logic                accept, has_lit, fin, is_end, is_err;
    t_kind               fin_kind;
    logic [LEN_W-1:0]    fin_len, copy_len;
    logic [OFF_W-1:0]    fin_off;
    logic [OFF_W:0]      s_wp, s_rd, s_bw, s_wp2;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        cur_phase = i_frame_start ? P_HDR0 : r_phase;
        cur_skip  = i_frame_start ? 3'd0 : r_skip;
        cur_wp    = i_frame_start ? '0 : r_wp;
        cur_bw    = i_frame_start ? '0 : r_bw;
    end

    // operand selection for the shared command decoder
    always_comb begin
        unique case (cur_phase)
            P_CMD0:  begin d0 = i_byte; d1 = '0;     d2 = '0;     d3 = '0;     end
            P_CMD1:  begin d0 = r_c0;   d1 = i_byte; d2 = '0;     d3 = '0;     end
            P_CMD2:  begin d0 = r_c0;   d1 = r_c1;   d2 = i_byte; d3 = '0;     end
            default: begin d0 = r_c0;   d1 = r_c1;   d2 = r_c2;   d3 = i_byte; end
        endcase
        dec = decode(d0, d1, d2, d3);
    end

    always_comb begin
        n_phase  = cur_phase;
        n_c0     = r_c0;
        n_c1     = r_c1;
        n_c2     = r_c2;
        n_lrem   = i_frame_start ? '0 : r_lrem;
        n_kind   = r_kind;
        n_len    = i_frame_start ? '0 : r_len;
        n_off    = i_frame_start ? '0 : r_off;
        n_skip   = cur_skip;
        has_lit  = 1'b0;
        fin      = 1'b0;
        fin_kind = dec.kind;
        fin_len  = dec.len;
        fin_off  = dec.off;
        is_end   = 1'b0;
        is_err   = 1'b0;
        copy_len = '0;

        unique case (cur_phase)
            P_HDR0: begin
                if ((i_byte & BYTE_MAGIC_MASK) != BYTE_MAGIC) begin
                    n_phase = P_ERR;
                    is_err  = 1'b1;
                end else begin
                    n_skip  = i_byte[0] ? SKIP_LONG : SKIP_SHORT;
                    n_phase = P_HDR1;
                end
            end
            P_HDR1: begin
                if (i_byte != BYTE_HDR1) begin
                    n_phase = P_ERR;
                    is_err  = 1'b1;
                end else begin
                    n_phase = P_SKIP;
                end
            end
            P_SKIP: begin
                n_skip = (cur_skip != 3'd0) ? cur_skip - 3'd1 : 3'd0;
                if (n_skip == 3'd0) n_phase = P_CMD0;
            end
            P_CMD0, P_CMD1, P_CMD2, P_CMD3: begin
                if (cur_phase == P_CMD0) n_c0 = i_byte;
                if (cur_phase == P_CMD1) n_c1 = i_byte;
                if (cur_phase == P_CMD2) n_c2 = i_byte;
                if ({1'b0, cmd_size(d0)} <= ({1'b0, cur_phase} - {1'b0, P_CMD0} + 4'd1))
                begin
                    if (dec.lit_n != '0) begin
                        n_phase = P_LIT;
                        n_lrem  = dec.lit_n;
                        n_kind  = dec.kind;
                        n_len   = dec.len;
                        n_off   = dec.off;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    n_phase = t_phase'(cur_phase + 4'd1);
                end
            end
            P_LIT: begin
                has_lit  = 1'b1;
                n_lrem   = (r_lrem != '0) ? r_lrem - 7'd1 : '0;
                fin_kind = r_kind;
                fin_len  = r_len;
                fin_off  = r_off;
                if (n_lrem == '0) fin = 1'b1;
            end
            default: ;
        endcase

        s_wp = {2'b00, cur_wp} + 19'(has_lit);
        if (s_wp >= WIN) s_wp = '0;
        wp1 = s_wp[ADDR_W-1:0];
        bw1 = cur_bw;
        if (has_lit && ({1'b0, cur_bw} < WIN)) bw1 = cur_bw + 18'd1;

        if (fin) begin
            unique case (fin_kind)
                K_TERM: begin
                    is_end  = 1'b1;
                    n_phase = P_DONE;
                end
                K_LONGLIT: n_phase = P_CMD0;
                default: begin
                    if ({1'b0, fin_off} > {1'b0, bw1}) begin
                        is_err  = 1'b1;
                        n_phase = P_ERR;
                    end else begin
                        copy_len = fin_len;
                        n_phase  = P_CMD0;
                    end
                end
            endcase
        end

        // copy source, new write pointer and saturated fill
        s_rd = {2'b00, wp1} + WIN - {1'b0, fin_off};
        if (s_rd >= WIN) s_rd = s_rd - WIN;
        s_wp2 = {2'b00, wp1} + 19'(copy_len);
        if (s_wp2 >= WIN) s_wp2 = s_wp2 - WIN;
        if (s_wp2 >= WIN) s_wp2 = s_wp2 - WIN;
        n_wp = s_wp2[ADDR_W-1:0];
        s_bw = {1'b0, bw1} + 19'(copy_len);
        n_bw = (s_bw > WIN) ? WIN[ADDR_W:0] : s_bw[ADDR_W:0];
    end

    assign o_push          = accept && (has_lit || (copy_len != '0) || is_end || is_err);
    assign o_cmd.has_lit   = has_lit;
    assign o_cmd.lit       = i_byte;
    assign o_cmd.len       = copy_len;
    assign o_cmd.wr_addr   = cur_wp;
    assign o_cmd.rd_addr   = s_rd[ADDR_W-1:0];
    assign o_cmd.is_end    = is_end;
    assign o_cmd.is_err    = is_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_HDR0;
            r_c0    <= '0;
            r_c1    <= '0;
            r_c2    <= '0;
            r_lrem  <= '0;
            r_kind  <= K_COPY;
            r_len   <= '0;
            r_off   <= '0;
            r_skip  <= '0;
            r_wp    <= '0;
            r_bw    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_c0    <= n_c0;
            r_c1    <= n_c1;
            r_c2    <= n_c2;
            r_lrem  <= n_lrem;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_off   <= n_off;
            r_skip  <= n_skip;
            r_wp    <= n_wp;
            r_bw    <= n_bw;
        end
    end

endmodule
`default_nettype wire

/* design/lzrp_fifo.sv */
`default_nettype none
module lzrp_fifo import lzrp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop) r_rptr <= r_rptr + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

/* design/lzrp_back.sv */
`default_nettype none
module lzrp_back import lzrp_pkg::*; #(
    parameter int WINDOW_BYTES     = 131072,
    parameter int BYTES_PER_RESULT = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  t_cmd               i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [8*MAX_BPR-1:0] o_bytes,
    output logic [5:0]         o_count,
    output logic               o_last,
    output logic               o_end,
    output logic               o_err
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [5:0] BPR = 6'(BYTES_PER_RESULT);

    typedef enum logic [2:0] {S_IDLE, S_LIT, S_COPY, S_WR, S_FLUSH} t_state;

    t_state            r_state;
    t_cmd              r_ent;
    logic [LEN_W-1:0]  r_rem;
    logic [AW-1:0]     r_wr, r_rd;
    logic [7:0]        r_acc [MAX_BPR];
    logic [5:0]        r_cnt;
    logic [7:0]        r_rdata;
    logic [7:0]        r_win [WINDOW_BYTES];
    logic              r_ovalid, r_olast, r_oend, r_oerr;
    logic [8*MAX_BPR-1:0] r_obytes;
    logic [5:0]        r_ocnt;

    logic              slot_free, we, re, flush_mid, emit;
    logic [7:0]        wdata;
    logic [8*MAX_BPR-1:0] packed_bytes;

    assign slot_free = !r_ovalid || i_ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign we        = (r_state == S_LIT) || (r_state == S_WR);
    assign wdata     = (r_state == S_LIT) ? r_ent.lit : r_rdata;
    // a full beat with more to come goes out before the next read
    assign flush_mid = (r_state == S_COPY) && (r_rem != '0) && (r_cnt == BPR);
    assign re        = (r_state == S_COPY) && (r_rem != '0) && (r_cnt != BPR);
    assign emit      = slot_free && (flush_mid || (r_state == S_FLUSH));

    always_comb begin
        for (int i = 0; i < MAX_BPR; i++) begin
            packed_bytes[8*i +: 8] = (6'(i) < r_cnt) ? r_acc[i] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_win[r_wr] <= wdata;
        if (re) r_rdata <= r_win[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_ent   <= i_cmd;
                        r_rem   <= i_cmd.len;
                        r_wr    <= i_cmd.wr_addr[AW-1:0];
                        r_rd    <= i_cmd.rd_addr[AW-1:0];
                        r_state <= i_cmd.has_lit ? S_LIT : S_COPY;
                    end
                end
                S_LIT: begin
                    r_acc[r_cnt[4:0]] <= r_ent.lit;
                    r_cnt   <= r_cnt + 6'd1;
                    r_wr    <= (r_wr == AW'(WINDOW_BYTES - 1)) ? '0 : r_wr + 1'b1;
                    r_state <= S_COPY;
                end
                S_COPY: begin
                    if (r_rem == '0) begin
                        r_state <= S_FLUSH;
                    end else if (flush_mid) begin
                        if (slot_free) begin
                            r_obytes <= packed_bytes;
                            r_ocnt   <= r_cnt;
                            r_olast  <= 1'b0;
                            r_oend   <= 1'b0;
                            r_oerr   <= 1'b0;
                            r_cnt    <= '0;
                        end
                    end else begin
                        r_rd    <= (r_rd == AW'(WINDOW_BYTES - 1)) ? '0 : r_rd + 1'b1;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_acc[r_cnt[4:0]] <= r_rdata;
                    r_cnt   <= r_cnt + 6'd1;
                    r_rem   <= r_rem - 1'b1;
                    r_wr    <= (r_wr == AW'(WINDOW_BYTES - 1)) ? '0 : r_wr + 1'b1;
                    r_state <= S_COPY;
                end
                S_FLUSH: begin
                    if (slot_free) begin
                        r_obytes <= packed_bytes;
                        r_ocnt   <= r_cnt;
                        r_olast  <= 1'b1;
                        r_oend   <= r_ent.is_end;
                        r_oerr   <= r_ent.is_err;
                        r_cnt    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_bytes = r_obytes;
    assign o_count = r_ocnt;
    assign o_last  = r_olast;
    assign o_end   = r_oend;
    assign o_err   = r_oerr;

endmodule
`default_nettype wire

/* design/lz77_refpack_decompressor.sv */
// throughput: the front takes one byte per cycle while its 4-entry queue has room;
//   the back takes one queue entry at a time and writes its literal into the window,
//   then reads and writes the window memory per copied byte, and pauses to send each beat
// reset: synchronous active-low; clears parse state, queue and output valid,
//   the history window is not cleared and needs no clearing pass
`default_nettype none
module lz77_refpack_decompressor import lzrp_pkg::*; #(
    parameter int WINDOW_BYTES     = 131072,
    parameter int BYTES_PER_RESULT = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // in_byte
    input  wire logic [0:0]   i_s_tuser,   // frame_start
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [263:0]      o_m_tdata,   // bytes_lo, bytes_mid_lo, bytes_mid_hi, bytes_hi,
                                           // byte_count, zero pad
    output logic              o_m_tlast,   // run_last
    output logic [1:0]        o_m_tuser    // stream_end, format_error
);

    t_cmd                  push_cmd, head_cmd;
    logic                  push, pop, full, empty;
    logic [8*MAX_BPR-1:0]  out_bytes;
    logic [5:0]            out_count;
    logic                  out_end, out_err;

    lzrp_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .i_byte        (i_s_tdata),
        .i_frame_start (i_s_tuser[0]),
        .o_ready       (o_s_tready),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lzrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    lzrp_back #(
        .WINDOW_BYTES     (WINDOW_BYTES),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_bytes (out_bytes),
        .o_count (out_count),
        .o_last  (o_m_tlast),
        .o_end   (out_end),
        .o_err   (out_err)
    );

    assign o_m_tdata = {2'b00, out_count, out_bytes};
    assign o_m_tuser = {out_err, out_end};

endmodule
`default_nettype wire

/* design/lzrp_checker.sv */
`default_nettype none
module lzrp_checker #(
    parameter int BYTES_PER_RESULT = 32
) (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [263:0] o_m_tdata,
    input wire logic         o_m_tlast,
    input wire logic [1:0]   o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat changed while stalled");

    a_full_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |->
            o_m_tdata[261:256] == 6'(BYTES_PER_RESULT) && o_m_tuser == 2'b00)
        else $error("non-final beat not full or carries flags");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[261:256] <= 6'(BYTES_PER_RESULT))
        else $error("byte count above beat size");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> !o_m_tuser[1])
        else $error("end and error on the same beat");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind lz77_refpack_decompressor lzrp_checker #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
) u_lzrp_checker (.*);
`default_nettype wire
